### rtl/sirt_pkg.sv
// Shared constants and types for the signed integer to radix text converter.
// No dependencies; compiled first.
`default_nettype none

package sirt_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int unsigned VALUE_BITS_DEF = 32;
    localparam int unsigned MAX_RADIX_DEF  = 16;

    // Fixed field widths
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned RADIX_W     = 5;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned TABLE_W     = 2 * CFG_DATA_W;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CHARS_HIGH = 2'd2;

    // Reset values and the smallest usable radix
    localparam logic [RADIX_W-1:0]    RESET_RADIX       = 5'd10;
    localparam logic [CFG_DATA_W-1:0] RESET_CHARS_LOW   = 64'h3736353433323130;
    localparam logic [CFG_DATA_W-1:0] RESET_CHARS_HIGH  = 64'h6665646362613938;
    localparam logic [RADIX_W-1:0]    MIN_RADIX         = 5'd2;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

endpackage

`default_nettype wire

### rtl/sirt_if.sv
// Valid/ready channel interfaces for the radix text converter: input value,
// output character and configuration write. Depends on sirt_pkg.
`default_nettype none

interface sirt_in_if #(
    parameter int unsigned VALUE_BITS = sirt_pkg::VALUE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sirt_out_if;
    import sirt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              last;

    modport source (output valid, output character, output last, input ready);
    modport sink   (input valid, input character, input last, output ready);
endinterface

interface sirt_cfg_if;
    import sirt_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/signed_integer_to_radix_text.sv
// Signed integer to radix text converter: bit-serial division by the radix,
// digit stack, character lookup. Depends on sirt_pkg and the sirt_if interfaces.
//
//  channel  | dir | payload                  | transaction
//  ---------+-----+--------------------------+---------------------------
//  i_in     | in  | value (signed)           | one integer to convert
//  o_out    | out | character, last          | one text character
//  i_cfg    | in  | index, data              | one register write
//
// Each digit costs one division pass over all VALUE_BITS magnitude bits, one
// quotient bit per cycle through the restoring divide on the magnitude shift
// register. Characters then leave one per cycle while the output side takes them.
// i_in is ready only between items. The output register holds while o_out
// stalls; the last character may still wait there when the next item is taken.
// Reset is synchronous, active low; configuration writes are always taken.
`default_nettype none

module signed_integer_to_radix_text #(
    parameter int unsigned VALUE_BITS = sirt_pkg::VALUE_BITS_DEF,
    parameter int unsigned MAX_RADIX  = sirt_pkg::MAX_RADIX_DEF
) (
    input  wire      i_clk,
    input  wire      i_rst_n,
    sirt_in_if.sink  i_in,
    sirt_out_if.source o_out,
    sirt_cfg_if.sink i_cfg
);
    import sirt_pkg::*;

    localparam int unsigned DIG_W = $clog2(MAX_RADIX);
    localparam int unsigned REM_W = DIG_W + 1;
    localparam int unsigned BIT_W = $clog2(VALUE_BITS);
    localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

    // Configuration
    logic [RADIX_W-1:0]    r_radix;
    logic [CFG_DATA_W-1:0] r_chars_low;
    logic [CFG_DATA_W-1:0] r_chars_high;

    // Control
    t_state             r_state, n_state;
    logic               r_neg, n_neg;
    logic               r_qnz, n_qnz;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_ovalid, n_ovalid;

    // Datapath
    logic [VALUE_BITS-1:0] r_mag, n_mag;
    logic [DIG_W-1:0]      r_rem, n_rem;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [CHAR_W-1:0]     r_char, n_char;
    logic                  r_last, n_last;
    logic [DIG_W-1:0]      r_stack [VALUE_BITS];

    logic                  w_push;
    logic                  w_pop;
    logic                  w_in_acc;
    logic [VALUE_BITS-1:0] w_val;
    logic [VALUE_BITS-1:0] w_abs;
    logic [REM_W-1:0]      w_radix;
    logic [REM_W-1:0]      w_rem_sh;
    logic [REM_W-1:0]      w_diff;
    logic                  w_ge;
    logic [DIG_W-1:0]      w_digit;
    logic [3:0]            w_dig4;
    logic [TABLE_W-1:0]    w_table;
    logic [CHAR_W-1:0]     w_lookup;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid     = r_ovalid;
    assign o_out.character = r_char;
    assign o_out.last      = r_last;

    // Clamp the radix register to the usable range
    always_comb begin
        if (r_radix < MIN_RADIX) begin
            w_radix = REM_W'(MIN_RADIX);
        end else if (r_radix > RADIX_W'(MAX_RADIX)) begin
            w_radix = REM_W'(MAX_RADIX);
        end else begin
            w_radix = REM_W'(r_radix);
        end
    end

    assign w_val = i_in.value;
    assign w_abs = w_val[VALUE_BITS-1] ? (~w_val + VALUE_BITS'(1)) : w_val;

    // One restoring divide step: bring down the next magnitude bit
    assign w_rem_sh = {r_rem, r_mag[VALUE_BITS-1]};
    assign w_ge     = (w_rem_sh >= w_radix);
    assign w_diff   = w_rem_sh - w_radix;
    assign w_digit  = w_ge ? w_diff[DIG_W-1:0] : w_rem_sh[DIG_W-1:0];

    assign w_dig4   = 4'(r_stack[0]);
    assign w_table  = {r_chars_high, r_chars_low};
    assign w_lookup = w_table[{w_dig4, 3'b000} +: CHAR_W];

    always_comb begin
        n_state  = r_state;
        n_neg    = r_neg;
        n_qnz    = r_qnz;
        n_cnt    = r_cnt;
        n_ovalid = r_ovalid;
        n_mag    = r_mag;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_char   = r_char;
        n_last   = r_last;
        w_push   = 1'b0;
        w_pop    = 1'b0;

        if (r_ovalid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_mag   = w_abs;
                    n_neg   = w_val[VALUE_BITS-1];
                    n_rem   = '0;
                    n_bit   = '0;
                    n_qnz   = 1'b0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_mag = {r_mag[VALUE_BITS-2:0], w_ge};
                n_rem = w_digit;
                n_qnz = r_qnz | w_ge;
                n_bit = r_bit + BIT_W'(1);
                if (r_bit == BIT_W'(VALUE_BITS - 1)) begin
                    // End of pass: remainder is the next digit, quotient stays in r_mag
                    w_push = 1'b1;
                    n_cnt  = r_cnt + CNT_W'(1);
                    n_rem  = '0;
                    n_bit  = '0;
                    n_qnz  = 1'b0;
                    if (!(r_qnz | w_ge)) begin
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_ovalid = 1'b1;
                    if (r_neg) begin
                        n_char = MINUS_CHAR;
                        n_last = 1'b0;
                        n_neg  = 1'b0;
                    end else begin
                        n_char = w_lookup;
                        n_last = (r_cnt == CNT_W'(1));
                        n_cnt  = r_cnt - CNT_W'(1);
                        w_pop  = 1'b1;
                        if (r_cnt == CNT_W'(1)) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_neg        <= 1'b0;
            r_qnz        <= 1'b0;
            r_cnt        <= '0;
            r_ovalid     <= 1'b0;
            r_radix      <= RESET_RADIX;
            r_chars_low  <= RESET_CHARS_LOW;
            r_chars_high <= RESET_CHARS_HIGH;
        end else begin
            r_state  <= n_state;
            r_neg    <= n_neg;
            r_qnz    <= n_qnz;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_RADIX:      r_radix      <= i_cfg.data[RADIX_W-1:0];
                    REG_CHARS_LOW:  r_chars_low  <= i_cfg.data;
                    REG_CHARS_HIGH: r_chars_high <= i_cfg.data;
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_rem  <= n_rem;
        r_bit  <= n_bit;
        r_char <= n_char;
        r_last <= n_last;
    end

    // Digit stack: push at the bottom while dividing, pop from the bottom while emitting
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            for (int i = VALUE_BITS - 1; i > 0; i--) begin
                r_stack[i] <= r_stack[i-1];
            end
            r_stack[0] <= w_digit;
        end else if (w_pop) begin
            for (int i = 0; i < VALUE_BITS - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

endmodule

`default_nettype wire
